// File: design/debounced_press_counter_core_defines.svh
// Assertion macros for the debounced press counter core.
// Expect clk and rst in the scope of the asserting module.
`ifndef DEBOUNCED_PRESS_COUNTER_CORE_DEFINES_SVH
`define DEBOUNCED_PRESS_COUNTER_CORE_DEFINES_SVH

// same-cycle implication
`define DPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dpc_pkg.sv
// Shared types and constants for the debounced press counter core.
// No dependencies.
`default_nettype none

package dpc_pkg;

  localparam int KEY_COUNT = 24;
  localparam int KEY_IN_W = 24;
  localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int PRESS_W = $clog2(KEY_COUNT + 1);

  localparam int TICK_W = 32;
  localparam int COUNT_W = 16;
  localparam int RAW_W = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [KEY_IN_W-1:0] ENABLE_RESET = 24'h06C4FF;
  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 32'd960000;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd420;
  localparam logic [TICK_W-1:0] BONUS_RESET = 32'd288000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_ENABLE = 8'd0,
    REG_DEBOUNCE   = 8'd1,
    REG_LIMIT      = 8'd2,
    REG_BONUS      = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_IN_W-1:0] key_enable_mask;
    logic [TICK_W-1:0]   debounce_ticks;
    logic [COUNT_W-1:0]  click_limit;
    logic [TICK_W-1:0]   bonus_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/dpc_cfg_regs.sv
// Configuration register file for the debounced press counter core.
// Depends on dpc_pkg.
`default_nettype none

module dpc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output dpc_pkg::cfg_t                       cfg
);
  import dpc_pkg::*;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_enable_mask <= ENABLE_RESET;
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.click_limit <= LIMIT_RESET;
      cfg.bonus_ticks <= BONUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_ENABLE: cfg.key_enable_mask <= cfg_data[KEY_IN_W-1:0];
        REG_DEBOUNCE:   cfg.debounce_ticks <= cfg_data[TICK_W-1:0];
        REG_LIMIT:      cfg.click_limit <= cfg_data[COUNT_W-1:0];
        REG_BONUS:      cfg.bonus_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/dpc_elapsed_cmp.sv
// Shared elapsed-time unit: wrapping (now - stamp) compared against a hold-off.
// Depends on dpc_pkg.
`default_nettype none

module dpc_elapsed_cmp (
  input  wire logic [dpc_pkg::TICK_W-1:0] now,
  input  wire logic [dpc_pkg::TICK_W-1:0] stamp,
  input  wire logic [dpc_pkg::TICK_W-1:0] holdoff,
  output logic                            expired
);
  import dpc_pkg::*;

  logic [TICK_W-1:0] elapsed;

  assign elapsed = now - stamp;
  assign expired = elapsed > holdoff;

endmodule

`default_nettype wire

// File: design/debounced_press_counter_core.sv
// An input beat is accepted only in the idle state; the scan then visits the keys in order,
// and the bonus step loads the result register. No new beat is taken until that is done;
// the single elapsed-time compare unit visits one key per cycle and then the bonus timer.
// A result beat waits in the output register; a stalled result holds the bonus step.
// Reset clears key history, pending flags, stamps and counts; loads register defaults.
`default_nettype none

`include "debounced_press_counter_core_defines.svh"

module debounced_press_counter_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dpc_pkg::KEY_IN_W-1:0]   key_levels,
  input  wire logic [dpc_pkg::TICK_W-1:0]     now_ticks,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [4:0]                          new_presses,
  output logic [15:0]                         click_total,
  output logic                                bonus_active,
  output logic [5:0]                          raw_low,
  output logic [7:0]                          cc_number,
  output logic [6:0]                          cc_value
);
  import dpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BONUS
  } state_t;

  cfg_t cfg;

  state_t                state;
  logic [KEY_IDX_W-1:0]  key_idx;
  logic [KEY_COUNT-1:0]  scan_levels;
  logic [TICK_W-1:0]     scan_now;
  logic [KEY_COUNT-1:0]  previous_levels;
  logic [KEY_COUNT-1:0]  pending_keys;
  logic [TICK_W-1:0]     press_stamp [KEY_COUNT];
  logic [PRESS_W-1:0]    presses;
  logic [COUNT_W-1:0]    click_count;
  logic [RAW_W-1:0]      raw_count;
  logic                  active_flag;
  logic [TICK_W-1:0]     active_stamp;

  logic [KEY_COUNT-1:0]  masked_levels;
  logic                  in_beat;
  logic                  out_free;
  logic                  lvl;
  logic                  falling;
  logic [TICK_W-1:0]     unit_stamp;
  logic [TICK_W-1:0]     unit_holdoff;
  logic                  expired;
  logic [COUNT_W:0]      sum;
  logic [COUNT_W-1:0]    sat_count;
  logic [COUNT_W-1:0]    count_next;
  logic                  active_next;
  logic [TICK_W-1:0]     active_stamp_next;

  dpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  generate
    if (KEY_COUNT <= KEY_IN_W) begin : g_narrow
      assign masked_levels = key_levels[KEY_COUNT-1:0] & cfg.key_enable_mask[KEY_COUNT-1:0];
    end else begin : g_wide
      assign masked_levels = {{(KEY_COUNT-KEY_IN_W){1'b0}}, key_levels & cfg.key_enable_mask};
    end
  endgenerate

  assign in_stall = rst || (state != ST_IDLE);
  assign in_beat = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign lvl = scan_levels[key_idx];
  assign falling = previous_levels[key_idx] && !lvl;

  always_comb begin
    if (state == ST_BONUS) begin
      unit_stamp = active_stamp;
      unit_holdoff = cfg.bonus_ticks;
    end else begin
      unit_stamp = falling ? scan_now : press_stamp[key_idx];
      unit_holdoff = cfg.debounce_ticks;
    end
  end

  dpc_elapsed_cmp u_cmp (
    .now     (scan_now),
    .stamp   (unit_stamp),
    .holdoff (unit_holdoff),
    .expired (expired)
  );

  always_comb begin
    sum = {1'b0, click_count} + (COUNT_W + 1)'(presses);
    sat_count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    count_next = sat_count;
    active_next = active_flag;
    active_stamp_next = active_stamp;
    if (sat_count >= cfg.click_limit && !active_flag) begin
      count_next = cfg.click_limit;
      active_next = 1'b1;
      active_stamp_next = scan_now;
    end else if (active_flag && expired) begin
      count_next = '0;
      active_next = 1'b0;
      active_stamp_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key_idx <= '0;
      previous_levels <= '0;
      pending_keys <= '0;
      presses <= '0;
      click_count <= '0;
      raw_count <= '0;
      active_flag <= 1'b0;
      active_stamp <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < KEY_COUNT; i++) begin
        press_stamp[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != ST_BONUS) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            scan_levels <= masked_levels;
            scan_now <= now_ticks;
            key_idx <= '0;
            presses <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (falling) begin
            press_stamp[key_idx] <= scan_now;
            pending_keys[key_idx] <= 1'b1;
          end else if (expired) begin
            if (pending_keys[key_idx] && !lvl) begin
              presses <= presses + PRESS_W'(1);
            end
            pending_keys[key_idx] <= 1'b0;
          end
          if (key_idx == KEY_IDX_W'(KEY_COUNT - 1)) begin
            state <= ST_BONUS;
          end else begin
            key_idx <= key_idx + KEY_IDX_W'(1);
          end
        end
        ST_BONUS: begin
          if (out_free) begin
            click_count <= count_next;
            raw_count <= raw_count + RAW_W'(presses);
            active_flag <= active_next;
            active_stamp <= active_stamp_next;
            previous_levels <= scan_levels;
            out_valid <= 1'b1;
            new_presses <= 5'(presses);
            click_total <= count_next;
            bonus_active <= active_next;
            raw_low <= raw_count + RAW_W'(presses);
            cc_number <= count_next[10:3];
            cc_value <= {count_next[2:0], 4'b0000};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DPC_ASSERT_NEXT(a_accept_starts_scan, in_beat,
      state == ST_SCAN && key_idx == '0, "input beat did not start a key scan")
  `DPC_ASSERT_NEXT(a_scan_ends_in_bonus,
      state == ST_SCAN && key_idx == KEY_IDX_W'(KEY_COUNT - 1),
      state == ST_BONUS, "key scan did not hand over to the bonus step")
  `DPC_ASSERT_NEXT(a_bonus_loads_result, state == ST_BONUS && out_free,
      out_valid && state == ST_IDLE, "bonus step did not load a result beat")
  `DPC_ASSERT_NOW(a_press_bound, out_valid,
      ({3'b000, new_presses} <= 8'(KEY_COUNT)), "more presses than keys in one scan")

endmodule

`default_nettype wire
